/* src/assert_macros.svh */
// Assertion macros used by the alternating-bit sender.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define ABS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked in and out of reset.
`define ABS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/abs_pkg.sv */
// Package: word types, event codes and checksum constants of the sender.
package abs_pkg;

    localparam int MAX_BYTES         = 20;
    localparam int LANE_BYTES        = 4;
    localparam int NUM_LANES         = MAX_BYTES / LANE_BYTES;
    localparam int LANE_SUM_W        = 10;
    localparam int PAYLOAD_W         = MAX_BYTES * 8;
    localparam int DEF_PAYLOAD_BYTES = 20;
    localparam int TIMER_W           = 16;
    localparam logic [TIMER_W-1:0] TIMEOUT_RST = 16'd15;

    typedef enum logic [1:0] {
        OP_MSG  = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]         operation;
        logic [63:0]        payload_lo;
        logic [63:0]        payload_mid;
        logic [31:0]        payload_hi;
        logic signed [31:0] in_seq;
        logic signed [31:0] in_ack;
        logic signed [31:0] in_checksum;
    } t_in_word;

    typedef struct packed {
        logic               send_valid;
        logic               out_seq;
        logic               out_ack;
        logic signed [31:0] out_checksum;
        logic [63:0]        out_payload_lo;
        logic [63:0]        out_payload_mid;
        logic [31:0]        out_payload_hi;
        logic               refused;
        logic               corrupt_ack;
        logic               awaiting;
    } t_out_word;

    typedef logic [NUM_LANES-1:0][LANE_SUM_W-1:0] t_lane_sums;

    function automatic logic [PAYLOAD_W-1:0] payload_mask(input int n_bytes);
        logic [PAYLOAD_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_BYTES; i++) begin
            if (i < n_bytes) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

/* src/abs_lane.sv */
// Checksum lane: adds the bytes of one slice of the payload.
module abs_lane
    import abs_pkg::*;
(
    input  logic [LANE_BYTES*8-1:0] i_bytes,
    output logic [LANE_SUM_W-1:0]   o_sum
);

    always_comb begin
        o_sum = '0;
        for (int i = 0; i < LANE_BYTES; i++) begin
            o_sum = o_sum + LANE_SUM_W'(i_bytes[i*8 +: 8]);
        end
    end

endmodule

/* src/abs_merge.sv */
// Checksum merge: adds the lane sums to the header base, wrapping at 32 bits.
module abs_merge
    import abs_pkg::*;
(
    input  t_lane_sums  i_lane_sums,
    input  logic [31:0] i_base,
    output logic [31:0] o_sum
);

    always_comb begin
        o_sum = i_base;
        for (int i = 0; i < NUM_LANES; i++) begin
            o_sum = o_sum + 32'(i_lane_sums[i]);
        end
    end

endmodule

/* src/alternating_bit_sender.sv */
// Alternating-bit sender: event handling, frame store, timer and output register.
//
// Input channel (i_in_valid / o_in_ready, i_in_word): one event per word,
// a message to frame, an arriving acknowledgement packet, or a timer tick.
// Output channel (o_out_valid / i_out_ready, o_out_word): exactly one
// result word per event: the frame sent (if any) and the refused,
// corrupt_ack and awaiting flags.
// Config: i_cfg_we writes i_cfg_wdata into the retransmit timeout.
// Throughput: one event per cycle while i_out_ready is high. o_out_valid rises in the
// cycle after acceptance. The payload checksum is formed by parallel byte lanes and a
// merge adder in the accepting cycle; the state update follows in the same cycle.
// A stalled output holds its word; a new event is still taken in the cycle
// the pending word leaves, so no bubble appears while i_out_ready is high.
// Reset: sequence bit 0, idle, timer stopped, timeout 15, output empty.
// The saved frame has no reset; it is only read after a message is framed.
module alternating_bit_sender
    import abs_pkg::*;
#(
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    `include "assert_macros.svh"

    localparam logic [PAYLOAD_W-1:0] MASK = payload_mask(PAYLOAD_BYTES);

    logic [TIMER_W-1:0]   r_timeout;
    logic                 r_seq, n_seq;
    logic                 r_waiting, n_waiting;
    logic [PAYLOAD_W-1:0] r_saved_payload, n_saved_payload;
    logic [31:0]          r_saved_chk, n_saved_chk;
    logic                 r_saved_seq, n_saved_seq;
    logic [TIMER_W-1:0]   r_timer_left, n_timer_left;
    logic                 r_timer_running, n_timer_running;
    logic                 r_out_valid;
    t_out_word            r_out_word, n_out_word;

    logic [PAYLOAD_W-1:0] payload;
    logic [31:0]          base;
    logic [31:0]          chk_sum;
    t_lane_sums           lane_sums;
    logic                 in_fire;
    t_op                  op;

    assign payload    = {i_in_word.payload_hi, i_in_word.payload_mid,
                         i_in_word.payload_lo} & MASK;
    assign op         = t_op'(i_in_word.operation);
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        if (op == OP_ACK) begin
            base = $unsigned(i_in_word.in_seq) + $unsigned(i_in_word.in_ack);
        end else begin
            base = {31'b0, r_seq};
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        abs_lane u_lane (
            .i_bytes (payload[g*LANE_BYTES*8 +: LANE_BYTES*8]),
            .o_sum   (lane_sums[g])
        );
    end

    abs_merge u_merge (
        .i_lane_sums (lane_sums),
        .i_base      (base),
        .o_sum       (chk_sum)
    );

    always_comb begin
        n_seq           = r_seq;
        n_waiting       = r_waiting;
        n_saved_payload = r_saved_payload;
        n_saved_chk     = r_saved_chk;
        n_saved_seq     = r_saved_seq;
        n_timer_left    = r_timer_left;
        n_timer_running = r_timer_running;
        n_out_word      = '0;
        unique case (op)
            OP_MSG: begin
                if (r_waiting) begin
                    n_out_word.refused = 1'b1;
                end else begin
                    n_saved_payload = payload;
                    n_saved_seq     = r_seq;
                    n_saved_chk     = chk_sum;
                    n_timer_left    = r_timeout;
                    n_timer_running = 1'b1;
                    n_waiting       = 1'b1;
                    n_out_word.send_valid      = 1'b1;
                    n_out_word.out_seq         = r_seq;
                    n_out_word.out_checksum    = $signed(chk_sum);
                    n_out_word.out_payload_lo  = payload[63:0];
                    n_out_word.out_payload_mid = payload[127:64];
                    n_out_word.out_payload_hi  = payload[159:128];
                end
            end
            OP_ACK: begin
                if ($unsigned(i_in_word.in_checksum) != chk_sum) begin
                    n_out_word.corrupt_ack = 1'b1;
                end else if (r_waiting &&
                             $unsigned(i_in_word.in_ack) == {31'b0, r_seq}) begin
                    n_timer_running = 1'b0;
                    n_timer_left    = '0;
                    n_seq           = ~r_seq;
                    n_waiting       = 1'b0;
                end
            end
            OP_TICK: begin
                if (r_timer_running) begin
                    if (r_timer_left <= TIMER_W'(1)) begin
                        n_timer_left = r_timeout;
                        n_out_word.send_valid      = 1'b1;
                        n_out_word.out_seq         = r_saved_seq;
                        n_out_word.out_checksum    = $signed(r_saved_chk);
                        n_out_word.out_payload_lo  = r_saved_payload[63:0];
                        n_out_word.out_payload_mid = r_saved_payload[127:64];
                        n_out_word.out_payload_hi  = r_saved_payload[159:128];
                    end else begin
                        n_timer_left = r_timer_left - TIMER_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
        n_out_word.awaiting = n_waiting;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout       <= TIMEOUT_RST;
            r_seq           <= 1'b0;
            r_waiting       <= 1'b0;
            r_timer_left    <= '0;
            r_timer_running <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_seq           <= n_seq;
                r_waiting       <= n_waiting;
                r_timer_left    <= n_timer_left;
                r_timer_running <= n_timer_running;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_saved_payload <= n_saved_payload;
            r_saved_chk     <= n_saved_chk;
            r_saved_seq     <= n_saved_seq;
            r_out_word      <= n_out_word;
        end
    end

    `ABS_ASSERT(a_timer_needs_wait, i_clk, i_rst_n,
        r_timer_running |-> r_waiting, "timer running while idle")
    `ABS_ASSERT(a_msg_starts_wait, i_clk, i_rst_n,
        (in_fire && op == OP_MSG && !r_waiting) |=> (r_waiting && r_timer_running),
        "framed message did not start waiting")
    `ABS_ASSERT(a_flags_exclusive, i_clk, i_rst_n,
        r_out_valid |-> !(r_out_word.send_valid &&
                          (r_out_word.refused || r_out_word.corrupt_ack)),
        "frame sent together with refused or corrupt flag")

endmodule

/* bench/tb_alternating_bit_sender.sv */
// Testbench for the alternating-bit sender: queued event words, in-line sender model, scoreboard.
module tb_alternating_bit_sender
    import abs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_WORDS = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_word    in_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_word   out_word;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    t_in_word    pending_words[$];
    t_out_word   owed_words[$];
    int          send_idle_pct = 0;
    int          out_stall_pct = 0;
    int          phase_items = 0;
    int          errors = 0;
    bit          word_taken = 1'b0;
    logic        gen_seq = 1'b0;

    // sender state mirrored in the bench
    logic [15:0]  timeout_ticks = TIMEOUT_RST;
    logic         seq_now = 1'b0;
    logic         awaiting_ack = 1'b0;
    logic [159:0] held_payload = '0;
    logic [31:0]  held_checksum = '0;
    logic         held_seq = 1'b0;
    logic [15:0]  ticks_left = '0;
    logic         timer_on = 1'b0;

    alternating_bit_sender u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] byte_total(logic [159:0] pl);
        logic [31:0] s;
        s = '0;
        for (int i = 0; i < DEF_PAYLOAD_BYTES; i++) begin
            s = s + 32'(pl[i*8 +: 8]);
        end
        return s;
    endfunction

    function automatic t_out_word held_frame();
        t_out_word f;
        f = '0;
        f.send_valid   = 1'b1;
        f.out_seq      = held_seq;
        f.out_checksum = held_checksum;
        {f.out_payload_hi, f.out_payload_mid, f.out_payload_lo} = held_payload;
        return f;
    endfunction

    task automatic sender_step(t_in_word w);
        t_out_word    r;
        logic [159:0] pl;
        logic [31:0]  sum;
        r  = '0;
        pl = {w.payload_hi, w.payload_mid, w.payload_lo};
        case (w.operation)
            OP_MSG: begin
                if (awaiting_ack) begin
                    r.refused = 1'b1;
                end else begin
                    held_payload  = pl;
                    held_seq      = seq_now;
                    held_checksum = {31'd0, seq_now} + byte_total(pl);
                    r             = held_frame();
                    ticks_left    = timeout_ticks;
                    timer_on      = 1'b1;
                    awaiting_ack  = 1'b1;
                end
            end
            OP_ACK: begin
                sum = w.in_seq + w.in_ack + byte_total(pl);
                if (sum != w.in_checksum) begin
                    r.corrupt_ack = 1'b1;
                end else if (awaiting_ack && w.in_ack == {31'd0, seq_now}) begin
                    timer_on     = 1'b0;
                    ticks_left   = '0;
                    seq_now      = ~seq_now;
                    awaiting_ack = 1'b0;
                end
            end
            OP_TICK: begin
                if (timer_on) begin
                    // zero timeout counts as one
                    if (ticks_left <= 16'd1) begin
                        r          = held_frame();
                        ticks_left = timeout_ticks;
                    end else begin
                        ticks_left = ticks_left - 16'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.awaiting = awaiting_ack;
        owed_words.push_back(r);
    endtask

    task automatic report(string what);
        errors++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            report($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    function automatic logic [159:0] any_payload();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom, $urandom, $urandom, $urandom};
        endcase
    endfunction

    function automatic t_in_word make_word(logic [1:0] op, logic [159:0] pl);
        t_in_word w;
        w.operation = op;
        {w.payload_hi, w.payload_mid, w.payload_lo} = pl;
        w.in_seq      = $urandom;
        w.in_ack      = $urandom;
        w.in_checksum = $urandom;
        return w;
    endfunction

    function automatic t_in_word ack_word(logic [31:0] seqno, logic [31:0] ackno,
                                          logic [159:0] pl, logic intact);
        t_in_word w;
        w = make_word(OP_ACK, pl);
        w.in_seq      = seqno;
        w.in_ack      = ackno;
        w.in_checksum = seqno + ackno + byte_total(pl);
        if (!intact) begin
            w.in_checksum = w.in_checksum + 32'($urandom_range(32'hFFFF_FFFF, 1));
        end
        return w;
    endfunction

    task automatic push(t_in_word w);
        pending_words.push_back(w);
        phase_items++;
    endtask

    task automatic close_exchange(logic [31:0] seqno, logic [159:0] pl);
        push(ack_word(seqno, {31'd0, gen_seq}, pl, 1'b1));
        gen_seq = ~gen_seq;
    endtask

    // message, some traffic while it is outstanding, then usually the matching ack
    task automatic queue_exchange();
        int n;
        n = ($urandom_range(4) == 0) ? $urandom_range(30, 8) : $urandom_range(6, 0);
        push(make_word(OP_MSG, any_payload()));
        repeat (n) begin
            case ($urandom_range(9))
                0: push(make_word(OP_MSG, any_payload()));
                1: push(ack_word($urandom, {31'd0, gen_seq}, any_payload(), 1'b0));
                2: push(ack_word($urandom, $urandom_range(1) ? {31'd0, ~gen_seq} : $urandom,
                                 any_payload(), 1'b1));
                3: push(make_word(2'($urandom_range(3)), any_payload()));
                default: push(make_word(OP_TICK, any_payload()));
            endcase
        end
        if ($urandom_range(9) != 0) begin
            close_exchange($urandom, any_payload());
        end
    endtask

    task automatic settle();
        while (pending_words.size() != 0 || in_valid || owed_words.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic set_timeout(logic [15:0] v);
        @(negedge clk);
        cfg_we        <= 1'b1;
        cfg_wdata     <= v;
        timeout_ticks = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [15:0] tmo, int sidle, int rstall);
        settle();
        set_timeout(tmo);
        send_idle_pct = sidle;
        out_stall_pct = rstall;
        phase_items   = 0;
        while (phase_items < PHASE_WORDS) begin
            queue_exchange();
        end
    endtask

    // input side: acceptance feeds the model, new words go out on the falling edge
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            sender_step(in_word);
            word_taken = 1'b1;
        end
    end

    always @(negedge clk) begin
        if (!in_valid || word_taken) begin
            word_taken = 1'b0;
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge clk) begin : monitor
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (owed_words.size() == 0) begin
                report("result word with no event outstanding");
            end else begin
                want = owed_words.pop_front();
                check_field("send_valid", 64'(out_word.send_valid), 64'(want.send_valid));
                check_field("out_seq", 64'(out_word.out_seq), 64'(want.out_seq));
                check_field("out_ack", 64'(out_word.out_ack), 64'(want.out_ack));
                check_field("out_checksum", 64'(out_word.out_checksum),
                            64'(want.out_checksum));
                check_field("out_payload_lo", out_word.out_payload_lo, want.out_payload_lo);
                check_field("out_payload_mid", out_word.out_payload_mid, want.out_payload_mid);
                check_field("out_payload_hi", 64'(out_word.out_payload_hi),
                            64'(want.out_payload_hi));
                check_field("refused", 64'(out_word.refused), 64'(want.refused));
                check_field("corrupt_ack", 64'(out_word.corrupt_ack), 64'(want.corrupt_ack));
                check_field("awaiting", 64'(out_word.awaiting), 64'(want.awaiting));
            end
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle: tick, intact and corrupt acks, unused code
        push(make_word(OP_TICK, any_payload()));
        push(ack_word($urandom, 32'd0, any_payload(), 1'b1));
        push(ack_word($urandom, 32'd0, '1, 1'b0));
        push(make_word(OP_UNUSED, '1));
        // frame, refusal and countdown under the reset timeout
        push(make_word(OP_MSG, '0));
        push(make_word(OP_MSG, '1));
        push(make_word(OP_TICK, '0));
        push(make_word(OP_TICK, '1));
        close_exchange(32'd0, '0);
        settle();

        // zero timeout resends on every tick
        set_timeout(16'd0);
        push(make_word(OP_MSG, '1));
        push(make_word(OP_TICK, any_payload()));
        push(make_word(OP_TICK, any_payload()));
        push(ack_word($urandom, {31'd0, ~gen_seq}, any_payload(), 1'b1));
        push(ack_word(32'h7FFF_FFFF, 32'h8000_0000, '1, 1'b1));
        push(ack_word(32'hFFFF_FFFF, {31'd0, gen_seq}, '1, 1'b0));
        push(make_word(OP_MSG, '0));
        close_exchange(32'hFFFF_FFFF, '1);
        push(make_word(OP_MSG, '0));
        push(make_word(OP_UNUSED, '0));
        push(make_word(OP_TICK, '1));
        close_exchange(32'h8000_0000, '1);

        run_phase(16'd2, 0, 0);
        run_phase(16'd1, 65, 0);
        run_phase(16'hFFFF, 0, 65);
        run_phase(16'($urandom_range(12, 3)), 8, 8);
        run_phase(16'd15, 0, 0);

        settle();
        repeat (8) @(posedge clk);
        if (errors == 0) begin
            $display("alternating_bit_sender test passed");
        end else begin
            $display("alternating_bit_sender test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("alternating_bit_sender test failed");
        $finish;
    end

endmodule
